@@ design/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg: shared constants for the sorting store
// Beat widths and field positions used by the top level and its checker.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int DATA_W      = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int TUSER_DUP   = 0;
  localparam int TUSER_OVF   = 1;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

@@ design/sort_and_flag_duplicates.sv @@
// ----------------------------------------------------------------------------
// sort_and_flag_duplicates: insertion-sorting store with duplicate flags
// Collects signed values into an ascending store; on the last beat of a set
// streams the store out in order, flagging repeats and capacity overflow.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata              | tuser                        | tlast
// in_     | slave     | value[31:0]        | -                            | last
// out_    | master    | value_res[31:0]    | [0] is_duplicate [1] overflow| last_res
//
// Insertion: one compare unit and one memory port walk the store from the top
// down: an empty or full store takes the beat in ST_IDLE; else each greater entry
// is read (ST_RD) and moved up (ST_CMP), the value landing above the first entry
// not greater or at slot 0 (ST_PLACE). Readout: ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT.
// in_tready is high only while idle; a stalled result holds in the output
// register. Reset (rst_n low, synchronous) empties the store; no clearing pass.
module sort_and_flag_duplicates #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sfd_pkg::DATA_W-1:0]       in_tdata,   // [31:0] value
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sfd_pkg::DATA_W-1:0]       out_tdata,  // [31:0] value_res
  output logic [sfd_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] is_duplicate, [1] overflow
  output logic                             out_tlast
);
  import sfd_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_PLACE,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  data_t           v_r, v_nxt;
  logic            last_r, last_nxt;
  data_t           prev_r, prev_nxt;
  data_t           out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_dup_r, out_dup_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  data_t           store_mem [CAPACITY];
  data_t           rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  data_t           wr_data;
  logic            in_fire;
  logic            cmp_gt;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign rd_addr    = (state_r == ST_OUT_RD) ? k_r : idx_r;
  assign cmp_gt     = (rd_data_r > v_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser[TUSER_DUP] = out_dup_r;
  assign out_tuser[TUSER_OVF] = out_ovf_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    out_dup_nxt   = out_dup_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = v_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          v_nxt    = data_t'(in_tdata);
          last_nxt = in_tlast;
          k_nxt    = '0;
          if (fill_r == CW'(CAPACITY)) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? ST_OUT_RD : ST_IDLE;
          end else if (fill_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = data_t'(in_tdata);
            fill_nxt  = fill_r + CW'(1);
            state_nxt = in_tlast ? ST_OUT_RD : ST_IDLE;
          end else begin
            idx_nxt   = AW'(fill_r - CW'(1));
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (cmp_gt) begin
          wr_data = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = ST_RD;
          end
        end else begin
          wr_data   = v_r;
          fill_nxt  = fill_r + CW'(1);
          state_nxt = last_r ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = v_r;
        fill_nxt  = fill_r + CW'(1);
        state_nxt = last_r ? ST_OUT_RD : ST_IDLE;
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_data_nxt  = rd_data_r;
        out_dup_nxt   = (k_r != '0) && (rd_data_r == prev_r);
        out_last_nxt  = (CW'(k_r) + CW'(1) == fill_r);
        out_ovf_nxt   = ovf_r;
        out_valid_nxt = 1'b1;
        prev_nxt      = rd_data_r;
        state_nxt     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
    idx_r      <= idx_nxt;
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
    out_dup_r  <= out_dup_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

@@ design/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks for the sorting store
// Watches the stream ports of the top level over time; bound below.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sfd_pkg::DATA_W-1:0]       out_tdata,
  input logic [sfd_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                             out_tlast
);
  import sfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result beat is pending");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("block not idle after final result beat");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result beat or busy state after reset");

endmodule

bind sort_and_flag_duplicates sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
